// File: rtl/pidc_pkg.sv
// pidc_pkg: shared widths, codes, control word layout and microcode ROM
// for the clamped PID controller. No dependencies; used by pidc_seq and
// pid_controller_clamped.
package pidc_pkg;

    // Data formats
    localparam int DATA_W    = 32;              // signed Q16.16 values
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = 48;              // error sum
    localparam int DT_W      = 32;              // unsigned Q8.24 seconds
    localparam int DT_FRAC_W = 24;
    localparam int CAP_W     = DATA_W - 1;
    localparam int ERR_W     = DATA_W + 1;
    localparam int DELTA_W   = DATA_W + 2;
    localparam int IDX_W     = 3;
    localparam int EN_W      = 3;
    localparam int OLIM_W    = 2;

    // Datapath sizes
    localparam int MA_W      = 34;              // multiplier A operand
    localparam int MB_W      = 32;              // multiplier B operand
    localparam int PROD_W    = MA_W + MB_W;
    localparam int CHUNK_W   = 32;              // partial product step
    localparam int PT_W      = 79;              // |ki| * |sum|
    localparam int ACC_W     = 111;             // |ki| * |sum| * dt
    localparam int TERM_W    = 63;
    localparam int TERM_CAP_LOG = 61;
    localparam int DRV_ACC_W = 64;
    localparam int DIV_PRE   = DT_FRAC_W - FRAC_W;
    localparam int DIV_N     = 73;              // quotient bits of the D term
    localparam int CNT_W     = 7;
    localparam int PC_W      = 5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_N - 1);
    localparam logic [ACC_W-1:0] TERM_CAP = ACC_W'(1) << TERM_CAP_LOG;
    localparam logic [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] DRV_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DRV_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Input function codes
    localparam logic [1:0] FUNC_SET  = 2'd0;
    localparam logic [1:0] FUNC_FB   = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_KP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI  = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD  = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAP = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIN = 3'd5;
    localparam logic [IDX_W-1:0] REG_EN  = 3'd6;

    // limit_enables bits
    localparam int EN_CAP = 0;
    localparam int EN_MAX = 1;
    localparam int EN_MIN = 2;

    // output_limited codes
    localparam logic [OLIM_W-1:0] OLIM_NONE = 2'd0;
    localparam logic [OLIM_W-1:0] OLIM_MAX  = 2'd1;
    localparam logic [OLIM_W-1:0] OLIM_MIN  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_ERR, OP_SUM, OP_CAP, OP_LATCH, OP_TERM, OP_ADDT, OP_SAT, OP_LIM
    } op_t;

    typedef enum logic [2:0] {
        AS_ERR, AS_DELTA, AS_SUM_LO, AS_SUM_HI, AS_P0, AS_P1, AS_P2
    } asel_t;

    typedef enum logic [1:0] {BS_KP, BS_KI, BS_KD, BS_DT} bsel_t;

    typedef enum logic [2:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SHL, ACC_DIV} acc_op_t;

    typedef enum logic [1:0] {SH0, SH32, SH64} acc_sh_t;

    typedef enum logic [1:0] {TK_P, TK_I, TK_D} term_t;

    typedef enum logic [1:0] {JC_NONE, JC_CNT, JC_DT0, JC_END} jc_t;

    typedef struct packed {
        op_t              op;
        logic             ld;
        asel_t            asel;
        bsel_t            bsel;
        logic             mul;
        acc_op_t          acc_op;
        acc_sh_t          acc_sh;
        term_t            tk;
        jc_t              jc;
        logic [PC_W-1:0]  jt;
        logic             cnt_ld;
    } ctrl_t;

    typedef struct packed {
        logic dt_zero;
        logic hold;
    } seq_cond_t;

    localparam logic [PC_W-1:0] PC_DIV = PC_W'(19);
    localparam logic [PC_W-1:0] PC_SAT = PC_W'(22);

    localparam ctrl_t CW_NOP = '{
        op: OP_NONE, ld: 1'b0, asel: AS_ERR, bsel: BS_KP, mul: 1'b0,
        acc_op: ACC_NONE, acc_sh: SH0, tk: TK_P, jc: JC_NONE,
        jt: '0, cnt_ld: 1'b0
    };

    function automatic logic [SUM_W-1:0] mag_of(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        r = v[SUM_W-1] ? (~v) + SUM_W'(1) : v;
        return r;
    endfunction

    // Tick program: error and sum, P term, I term (two multiply passes),
    // D term (multiply and bit-serial divide), saturate, limit.
    function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = CW_NOP;
        case (pc)
            5'd0: w.op = OP_ERR;
            5'd1: w.op = OP_SUM;
            5'd2: w.op = OP_CAP;
            5'd3: begin
                w.ld = 1'b1; w.asel = AS_ERR; w.bsel = BS_KP;
            end
            5'd4: begin
                w.mul = 1'b1;
                w.ld = 1'b1; w.asel = AS_SUM_LO; w.bsel = BS_KI;
            end
            5'd5: begin
                w.acc_op = ACC_LOAD; w.acc_sh = SH0; w.mul = 1'b1;
                w.ld = 1'b1; w.asel = AS_SUM_HI; w.bsel = BS_KI;
            end
            5'd6: begin
                w.op = OP_TERM; w.tk = TK_P;
                w.acc_op = ACC_LOAD; w.acc_sh = SH0; w.mul = 1'b1;
            end
            5'd7: begin
                w.op = OP_ADDT; w.acc_op = ACC_ADD; w.acc_sh = SH32;
            end
            5'd8: w.op = OP_LATCH;
            5'd9: begin
                w.ld = 1'b1; w.asel = AS_P0; w.bsel = BS_DT;
            end
            5'd10: begin
                w.mul = 1'b1;
                w.ld = 1'b1; w.asel = AS_P1; w.bsel = BS_DT;
            end
            5'd11: begin
                w.acc_op = ACC_LOAD; w.acc_sh = SH0; w.mul = 1'b1;
                w.ld = 1'b1; w.asel = AS_P2; w.bsel = BS_DT;
            end
            5'd12: begin
                w.acc_op = ACC_ADD; w.acc_sh = SH32; w.mul = 1'b1;
            end
            5'd13: begin
                w.acc_op = ACC_ADD; w.acc_sh = SH64;
            end
            5'd14: begin
                w.op = OP_TERM; w.tk = TK_I;
            end
            5'd15: begin
                w.op = OP_ADDT;
                w.ld = 1'b1; w.asel = AS_DELTA; w.bsel = BS_KD;
                w.jc = JC_DT0; w.jt = PC_SAT;
            end
            5'd16: w.mul = 1'b1;
            5'd17: begin
                w.acc_op = ACC_LOAD; w.acc_sh = SH0;
            end
            5'd18: begin
                w.acc_op = ACC_SHL; w.cnt_ld = 1'b1;
            end
            5'd19: begin
                w.acc_op = ACC_DIV; w.jc = JC_CNT; w.jt = PC_DIV;
            end
            5'd20: begin
                w.op = OP_TERM; w.tk = TK_D;
            end
            5'd21: w.op = OP_ADDT;
            5'd22: w.op = OP_SAT;
            5'd23: begin
                w.op = OP_LIM; w.jc = JC_END;
            end
            default: w.jc = JC_END;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pidc_seq.sv
// pidc_seq: microcode sequencer with step counter, loop counter and
// conditional jumps. Depends on pidc_pkg for the control word and ROM.
module pidc_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  pidc_pkg::seq_cond_t cond,
    output logic                active,
    output pidc_pkg::ctrl_t     cw
);

    logic                         active_reg, active_next;
    logic [pidc_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [pidc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    assign cw     = pidc_pkg::rom_word(pc_reg);
    assign active = active_reg;

    always_comb begin
        active_next = active_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg;
        if (!active_reg) begin
            if (start) begin
                active_next = 1'b1;
                pc_next     = '0;
            end
        end else if (!cond.hold) begin
            pc_next = pc_reg + pidc_pkg::PC_W'(1);
            if (cw.cnt_ld) begin
                cnt_next = pidc_pkg::DIV_LAST;
            end
            case (cw.jc)
                pidc_pkg::JC_CNT: begin
                    cnt_next = cnt_reg - pidc_pkg::CNT_W'(1);
                    if (cnt_reg != '0) begin
                        pc_next = cw.jt;
                    end
                end
                pidc_pkg::JC_DT0: begin
                    if (cond.dt_zero) begin
                        pc_next = cw.jt;
                    end
                end
                pidc_pkg::JC_END: begin
                    active_next = 1'b0;
                    pc_next     = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pc_reg     <= '0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/pid_controller_clamped.sv
// pid_controller_clamped: top level; config registers, controller state and
// the datapath (34x32 multiplier, accumulator, 1-bit/cycle divider), run by
// pidc_seq. Depends on pidc_pkg. Setpoint/feedback are accepted while no tick runs.
// A tick result is registered in the final step of the microcode program; the
// D term (shared multiplier, 73-step divider) is skipped when dt is zero.
// Synchronous active-low reset clears config, state and both handshakes.
module pid_controller_clamped (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidc_pkg::IDX_W-1:0]        cfg_addr,
    input  logic [pidc_pkg::DATA_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_func,
    input  logic signed [pidc_pkg::DATA_W-1:0] s_sample_value,
    input  logic [pidc_pkg::DT_W-1:0]         s_elapsed_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pidc_pkg::DATA_W-1:0] m_drive,
    output logic [pidc_pkg::OLIM_W-1:0]       m_output_limited,
    output logic                              m_integral_limited
);

    // Configuration
    logic [pidc_pkg::DATA_W-1:0] kp_reg, ki_reg, kd_reg, max_reg, min_reg;
    logic [pidc_pkg::CAP_W-1:0]  cap_reg;
    logic [pidc_pkg::EN_W-1:0]   en_reg;

    // Controller state
    logic [pidc_pkg::DATA_W-1:0]  target_reg, measured_reg;
    logic                         target_seen_reg, measure_seen_reg;
    logic [pidc_pkg::ERR_W-1:0]   cur_err_reg;
    logic [pidc_pkg::SUM_W-1:0]   err_sum_reg;

    // Datapath
    logic [pidc_pkg::DELTA_W-1:0]   delta_reg;
    logic [pidc_pkg::DT_W-1:0]      dt_reg;
    logic [pidc_pkg::MA_W-1:0]      mula_reg;
    logic [pidc_pkg::MB_W-1:0]      mulb_reg;
    logic [pidc_pkg::PROD_W-1:0]    prod_reg;
    logic [pidc_pkg::ACC_W-1:0]     acc_reg;
    logic [pidc_pkg::PT_W-1:0]      ptmp_reg;
    logic [pidc_pkg::DT_W-1:0]      rem_reg;
    logic [pidc_pkg::TERM_W-1:0]    term_reg;
    logic [pidc_pkg::DRV_ACC_W-1:0] drive_acc_reg;
    logic [pidc_pkg::DATA_W-1:0]    drv_sat_reg;
    logic                           ilim_reg;

    // Output register
    logic                          out_valid_reg;
    logic [pidc_pkg::DATA_W-1:0]   out_drive_reg;
    logic [pidc_pkg::OLIM_W-1:0]   out_olim_reg;
    logic                          out_ilim_reg;

    // Sequencer
    pidc_pkg::ctrl_t     cw;
    pidc_pkg::seq_cond_t cond;
    logic                seq_active;
    logic                in_fire, start, stall, step;

    // Combinational datapath values
    logic [pidc_pkg::ERR_W-1:0]     err_next;
    logic [pidc_pkg::DELTA_W-1:0]   delta_next;
    logic [pidc_pkg::SUM_W:0]       sum_wide;
    logic [pidc_pkg::SUM_W-1:0]     sum_next;
    logic [pidc_pkg::SUM_W-1:0]     sum_mag, cap_ext, cap_next;
    logic                           cap_over;
    logic [pidc_pkg::SUM_W-1:0]     err_mag, delta_mag, kp_mag, ki_mag, kd_mag;
    logic [pidc_pkg::MA_W-1:0]      mula_next;
    logic [pidc_pkg::MB_W-1:0]      mulb_next;
    logic [pidc_pkg::ACC_W-1:0]     acc_add;
    logic [pidc_pkg::DT_W:0]        rem_shift, rem_diff;
    logic                           q_bit;
    logic [pidc_pkg::ACC_W-1:0]     term_mag;
    logic [pidc_pkg::TERM_W-1:0]    term_lim, term_next;
    logic                           term_neg;
    logic [pidc_pkg::DRV_ACC_W-pidc_pkg::DATA_W:0] drv_hi;
    logic [pidc_pkg::DATA_W-1:0]    sat_next, lim_drive;
    logic [pidc_pkg::OLIM_W-1:0]    lim_code;

    assign cfg_ready = 1'b1;
    assign s_ready   = !seq_active;
    assign in_fire   = s_valid && s_ready;
    assign start     = in_fire && (s_func == pidc_pkg::FUNC_TICK)
                       && target_seen_reg && measure_seen_reg;
    // Hold the final step while the previous result is still waiting.
    assign stall     = seq_active && (cw.op == pidc_pkg::OP_LIM)
                       && out_valid_reg && !m_ready;
    assign step      = seq_active && !stall;

    assign cond.dt_zero = (dt_reg == '0);
    assign cond.hold    = stall;

    pidc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cond    (cond),
        .active  (seq_active),
        .cw      (cw)
    );

    assign m_valid            = out_valid_reg;
    assign m_drive            = out_drive_reg;
    assign m_output_limited   = out_olim_reg;
    assign m_integral_limited = out_ilim_reg;

    // Error, error delta and saturated error sum
    always_comb begin
        err_next   = {target_reg[pidc_pkg::DATA_W-1], target_reg}
                   - {measured_reg[pidc_pkg::DATA_W-1], measured_reg};
        delta_next = {{2{target_reg[pidc_pkg::DATA_W-1]}}, target_reg}
                   - {{2{measured_reg[pidc_pkg::DATA_W-1]}}, measured_reg}
                   - {cur_err_reg[pidc_pkg::ERR_W-1], cur_err_reg};
        sum_wide   = {err_sum_reg[pidc_pkg::SUM_W-1], err_sum_reg}
                   + {{(pidc_pkg::SUM_W+1-pidc_pkg::ERR_W){cur_err_reg[pidc_pkg::ERR_W-1]}},
                      cur_err_reg};
        if (sum_wide[pidc_pkg::SUM_W] != sum_wide[pidc_pkg::SUM_W-1]) begin
            sum_next = sum_wide[pidc_pkg::SUM_W] ? pidc_pkg::SUM_MIN : pidc_pkg::SUM_MAX;
        end else begin
            sum_next = sum_wide[pidc_pkg::SUM_W-1:0];
        end
    end

    // Integral cap
    always_comb begin
        sum_mag  = pidc_pkg::mag_of(err_sum_reg);
        cap_ext  = pidc_pkg::SUM_W'(cap_reg);
        cap_over = en_reg[pidc_pkg::EN_CAP] && (sum_mag > cap_ext);
        cap_next = err_sum_reg[pidc_pkg::SUM_W-1] ? (~cap_ext) + pidc_pkg::SUM_W'(1) : cap_ext;
    end

    // Multiplier operand selection
    always_comb begin
        err_mag   = pidc_pkg::mag_of({{(pidc_pkg::SUM_W-pidc_pkg::ERR_W)
                                       {cur_err_reg[pidc_pkg::ERR_W-1]}}, cur_err_reg});
        delta_mag = pidc_pkg::mag_of({{(pidc_pkg::SUM_W-pidc_pkg::DELTA_W)
                                       {delta_reg[pidc_pkg::DELTA_W-1]}}, delta_reg});
        kp_mag    = pidc_pkg::mag_of({{(pidc_pkg::SUM_W-pidc_pkg::DATA_W)
                                       {kp_reg[pidc_pkg::DATA_W-1]}}, kp_reg});
        ki_mag    = pidc_pkg::mag_of({{(pidc_pkg::SUM_W-pidc_pkg::DATA_W)
                                       {ki_reg[pidc_pkg::DATA_W-1]}}, ki_reg});
        kd_mag    = pidc_pkg::mag_of({{(pidc_pkg::SUM_W-pidc_pkg::DATA_W)
                                       {kd_reg[pidc_pkg::DATA_W-1]}}, kd_reg});
        case (cw.asel)
            pidc_pkg::AS_ERR:    mula_next = err_mag[pidc_pkg::MA_W-1:0];
            pidc_pkg::AS_DELTA:  mula_next = delta_mag[pidc_pkg::MA_W-1:0];
            pidc_pkg::AS_SUM_LO: mula_next = pidc_pkg::MA_W'(sum_mag[pidc_pkg::CHUNK_W-1:0]);
            pidc_pkg::AS_SUM_HI: mula_next = pidc_pkg::MA_W'(
                                     sum_mag[pidc_pkg::SUM_W-1:pidc_pkg::CHUNK_W]);
            pidc_pkg::AS_P0:     mula_next = pidc_pkg::MA_W'(ptmp_reg[pidc_pkg::CHUNK_W-1:0]);
            pidc_pkg::AS_P1:     mula_next = pidc_pkg::MA_W'(
                                     ptmp_reg[2*pidc_pkg::CHUNK_W-1:pidc_pkg::CHUNK_W]);
            pidc_pkg::AS_P2:     mula_next = pidc_pkg::MA_W'(
                                     ptmp_reg[pidc_pkg::PT_W-1:2*pidc_pkg::CHUNK_W]);
            default:             mula_next = '0;
        endcase
        case (cw.bsel)
            pidc_pkg::BS_KP: mulb_next = kp_mag[pidc_pkg::MB_W-1:0];
            pidc_pkg::BS_KI: mulb_next = ki_mag[pidc_pkg::MB_W-1:0];
            pidc_pkg::BS_KD: mulb_next = kd_mag[pidc_pkg::MB_W-1:0];
            pidc_pkg::BS_DT: mulb_next = dt_reg;
            default:         mulb_next = '0;
        endcase
    end

    // Accumulator input and divider step
    always_comb begin
        case (cw.acc_sh)
            pidc_pkg::SH32: acc_add = pidc_pkg::ACC_W'(prod_reg) << pidc_pkg::CHUNK_W;
            pidc_pkg::SH64: acc_add = pidc_pkg::ACC_W'(prod_reg) << (2 * pidc_pkg::CHUNK_W);
            default:        acc_add = pidc_pkg::ACC_W'(prod_reg);
        endcase
        rem_shift = {rem_reg, acc_reg[pidc_pkg::DIV_N-1]};
        rem_diff  = rem_shift - {1'b0, dt_reg};
        q_bit     = (rem_shift >= {1'b0, dt_reg});
    end

    // Term: scale, hold to the term cap, apply sign
    always_comb begin
        case (cw.tk)
            pidc_pkg::TK_P: begin
                term_mag = acc_reg >> pidc_pkg::FRAC_W;
                term_neg = kp_reg[pidc_pkg::DATA_W-1] ^ cur_err_reg[pidc_pkg::ERR_W-1];
            end
            pidc_pkg::TK_I: begin
                term_mag = acc_reg >> (pidc_pkg::FRAC_W + pidc_pkg::DT_FRAC_W);
                term_neg = ki_reg[pidc_pkg::DATA_W-1] ^ err_sum_reg[pidc_pkg::SUM_W-1];
            end
            default: begin
                term_mag = acc_reg;
                term_neg = kd_reg[pidc_pkg::DATA_W-1] ^ delta_reg[pidc_pkg::DELTA_W-1];
            end
        endcase
        term_lim  = (term_mag > pidc_pkg::TERM_CAP)
                  ? pidc_pkg::TERM_CAP[pidc_pkg::TERM_W-1:0]
                  : term_mag[pidc_pkg::TERM_W-1:0];
        term_next = term_neg ? (~term_lim) + pidc_pkg::TERM_W'(1) : term_lim;
    end

    // Saturate to the data width, then apply the enabled limits
    always_comb begin
        drv_hi = drive_acc_reg[pidc_pkg::DRV_ACC_W-1:pidc_pkg::DATA_W-1];
        if ((&drv_hi) || !(|drv_hi)) begin
            sat_next = drive_acc_reg[pidc_pkg::DATA_W-1:0];
        end else begin
            sat_next = drive_acc_reg[pidc_pkg::DRV_ACC_W-1] ? pidc_pkg::DRV_MIN
                                                            : pidc_pkg::DRV_MAX;
        end
        lim_drive = drv_sat_reg;
        lim_code  = pidc_pkg::OLIM_NONE;
        if (en_reg[pidc_pkg::EN_MAX] && ($signed(drv_sat_reg) > $signed(max_reg))) begin
            lim_drive = max_reg;
            lim_code  = pidc_pkg::OLIM_MAX;
        end else if (en_reg[pidc_pkg::EN_MIN]
                     && ($signed(drv_sat_reg) < $signed(min_reg))) begin
            lim_drive = min_reg;
            lim_code  = pidc_pkg::OLIM_MIN;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            cap_reg <= '0;
            max_reg <= '0;
            min_reg <= '0;
            en_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                pidc_pkg::REG_KP:  kp_reg  <= cfg_data;
                pidc_pkg::REG_KI:  ki_reg  <= cfg_data;
                pidc_pkg::REG_KD:  kd_reg  <= cfg_data;
                pidc_pkg::REG_CAP: cap_reg <= cfg_data[pidc_pkg::CAP_W-1:0];
                pidc_pkg::REG_MAX: max_reg <= cfg_data;
                pidc_pkg::REG_MIN: min_reg <= cfg_data;
                pidc_pkg::REG_EN:  en_reg  <= cfg_data[pidc_pkg::EN_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg       <= '0;
            measured_reg     <= '0;
            target_seen_reg  <= 1'b0;
            measure_seen_reg <= 1'b0;
            cur_err_reg      <= '0;
            err_sum_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (in_fire && (s_func == pidc_pkg::FUNC_SET)) begin
                target_reg      <= s_sample_value;
                target_seen_reg <= 1'b1;
            end
            if (in_fire && (s_func == pidc_pkg::FUNC_FB)) begin
                measured_reg     <= s_sample_value;
                measure_seen_reg <= 1'b1;
            end
            if (step && (cw.op == pidc_pkg::OP_ERR)) begin
                cur_err_reg <= err_next;
            end
            if (step && (cw.op == pidc_pkg::OP_SUM)) begin
                err_sum_reg <= sum_next;
            end
            if (step && (cw.op == pidc_pkg::OP_CAP) && cap_over) begin
                err_sum_reg <= cap_next;
            end
            if (step && (cw.op == pidc_pkg::OP_LIM)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            dt_reg <= s_elapsed_time;
        end
        if (step) begin
            if (cw.ld) begin
                mula_reg <= mula_next;
                mulb_reg <= mulb_next;
            end
            if (cw.mul) begin
                prod_reg <= mula_reg * mulb_reg;
            end
            case (cw.acc_op)
                pidc_pkg::ACC_LOAD: acc_reg <= acc_add;
                pidc_pkg::ACC_ADD:  acc_reg <= acc_reg + acc_add;
                pidc_pkg::ACC_SHL: begin
                    acc_reg <= acc_reg << pidc_pkg::DIV_PRE;
                    rem_reg <= '0;
                end
                pidc_pkg::ACC_DIV: begin
                    // shift the quotient bit in as the dividend bit leaves
                    acc_reg <= {acc_reg[pidc_pkg::ACC_W-1:pidc_pkg::DIV_N],
                                acc_reg[pidc_pkg::DIV_N-2:0], q_bit};
                    rem_reg <= q_bit ? rem_diff[pidc_pkg::DT_W-1:0]
                                     : rem_shift[pidc_pkg::DT_W-1:0];
                end
                default: ;
            endcase
            case (cw.op)
                pidc_pkg::OP_ERR: begin
                    delta_reg     <= delta_next;
                    drive_acc_reg <= '0;
                    ilim_reg      <= 1'b0;
                end
                pidc_pkg::OP_CAP: begin
                    if (cap_over) begin
                        ilim_reg <= 1'b1;
                    end
                end
                pidc_pkg::OP_LATCH: ptmp_reg <= acc_reg[pidc_pkg::PT_W-1:0];
                pidc_pkg::OP_TERM:  term_reg <= term_next;
                pidc_pkg::OP_ADDT: begin
                    drive_acc_reg <= drive_acc_reg
                                   + {{(pidc_pkg::DRV_ACC_W-pidc_pkg::TERM_W)
                                       {term_reg[pidc_pkg::TERM_W-1]}}, term_reg};
                end
                pidc_pkg::OP_SAT: drv_sat_reg <= sat_next;
                pidc_pkg::OP_LIM: begin
                    out_drive_reg <= lim_drive;
                    out_olim_reg  <= lim_code;
                    out_ilim_reg  <= ilim_reg;
                end
                default: ;
            endcase
        end
    end

endmodule
